>>> hdl/vdi_pkg.sv
// Shared types, sizes and the slot hash for the vertex dedup indexer.
package vdi_pkg;

   localparam int MAX_VERTICES = 4096;
   localparam int IDX_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W        = IDX_W + 1;
   localparam int SLOT_W       = IDX_W + 1;
   localparam int NUM_SLOTS    = 2 ** SLOT_W;
   localparam int KEY_W        = 256;
   localparam int ENTRY_W      = KEY_W + SLOT_W;
   localparam int OUT_IDX_W    = 12;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] tex_u;
      logic [31:0] tex_v;
      logic [31:0] norm_x;
      logic [31:0] norm_y;
      logic [31:0] norm_z;
      logic        start_of_mesh;
   } req_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] vtx_idx;
      logic                 is_new;
      logic                 overflow;
   } rsp_type;

   // XOR-fold the key into a slot number; each word lands at its own offset.
   function automatic logic [SLOT_W-1:0] slot_hash(input logic [KEY_W-1:0] key);
      logic [SLOT_W-1:0] h;
      h = '0;
      for (int i = 0; i < KEY_W; i++) begin
         h[(i + (i / 32) * 5) % SLOT_W] = h[(i + (i / 32) * 5) % SLOT_W] ^ key[i];
      end
      return h;
   endfunction

endpackage

>>> hdl/vdi_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module vdi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/vertex_dedup_indexer.sv
// Top level of the vertex dedup indexer: hash-probe control around two RAMs.
//
//   channel  | ports                    | handshake
//   ---------+--------------------------+-----------------------------------
//   request  | start, busy, req_data    | taken when start & !busy
//   response | rsp_valid, rsp_data      | one-cycle strobe, no backpressure
//
// Busy stays high from the accepting edge through hash, slot read, entry
// read, then compare or insert; an extra probe of the 2x MAX_VERTICES slot
// RAM (linear probing) reads slot and entry again; a stale pointer then inserts.
// The response strobe comes in the cycle after the decision; busy drops with it.
// Synchronous reset clears the entry count; RAM contents need no clearing, a
// slot is live only if its entry index is below the count and points back.
module vertex_dedup_indexer
   import vdi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_HASH   = 6'b000010,
      ST_SREAD  = 6'b000100,
      ST_SDATA  = 6'b001000,
      ST_EDATA  = 6'b010000,
      ST_INSERT = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic               slot_rd_en, slot_wr_en;
   logic [IDX_W-1:0]   slot_rd_data;
   logic               ent_rd_en, ent_wr_en;
   logic [ENTRY_W-1:0] ent_rd_data;
   logic [KEY_W-1:0]   ent_key;
   logic [SLOT_W-1:0]  ent_slot;

   assign ent_key  = ent_rd_data[KEY_W-1:0];
   assign ent_slot = ent_rd_data[ENTRY_W-1:KEY_W];

   vdi_ram #(.WIDTH(IDX_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_ff),
      .wr_data (count_ff[IDX_W-1:0]),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_ff),
      .rd_data (slot_rd_data)
   );

   vdi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTICES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({slot_ff, key_ff}),
      .rd_en   (ent_rd_en),
      .rd_addr (idx_in),
      .rd_data (ent_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      slot_rd_en   = 1'b0;
      slot_wr_en   = 1'b0;
      ent_rd_en    = 1'b0;
      ent_wr_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in = {req_data.pos_x, req_data.pos_y, req_data.pos_z,
                         req_data.tex_u, req_data.tex_v,
                         req_data.norm_x, req_data.norm_y, req_data.norm_z};
               if (req_data.start_of_mesh) begin
                  count_in = '0;
               end
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            slot_in  = slot_hash(key_ff);
            state_in = ST_SREAD;
         end
         ST_SREAD: begin
            slot_rd_en = 1'b1;
            state_in   = ST_SDATA;
         end
         ST_SDATA: begin
            idx_in = slot_rd_data;
            if ({1'b0, slot_rd_data} < count_ff) begin
               ent_rd_en = 1'b1;
               state_in  = ST_EDATA;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_EDATA: begin
            if (ent_slot == slot_ff) begin
               if (ent_key == key_ff) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.vtx_idx  = OUT_IDX_W'(idx_ff);
                  rsp_data_in.is_new   = 1'b0;
                  rsp_data_in.overflow = 1'b0;
                  state_in             = ST_IDLE;
               end else begin
                  // live slot of another key: advance the probe
                  slot_in  = slot_ff + 1'b1;
                  state_in = ST_SREAD;
               end
            end else begin
               // stale pointer from an earlier mesh: slot counts as empty
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            rsp_valid_in = 1'b1;
            if (count_ff == CNT_W'(MAX_VERTICES)) begin
               rsp_data_in.vtx_idx  = '0;
               rsp_data_in.is_new   = 1'b0;
               rsp_data_in.overflow = 1'b1;
            end else begin
               slot_wr_en           = 1'b1;
               ent_wr_en            = 1'b1;
               rsp_data_in.vtx_idx  = OUT_IDX_W'(count_ff[IDX_W-1:0]);
               rsp_data_in.is_new   = 1'b1;
               rsp_data_in.overflow = 1'b0;
               count_in             = count_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      slot_ff     <= slot_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
